### rtl/core/cpci_pkg.sv
// ----------------------------------------------------------------------------
// cpci_pkg
// Shared types, constants and helpers for the circle pair collision pipeline.
// ----------------------------------------------------------------------------
package cpci_pkg;

	// fixed point layout
	localparam int FRAC_BITS = 16;
	localparam int UNIT_BITS = 24;
	localparam int NQ        = UNIT_BITS + 1;  // quotient bits of a normal or share
	localparam int SQ_BITS   = 32;             // root bits of the square root unit

	localparam logic [NQ-1:0] UNIT = NQ'(1) << UNIT_BITS;
	localparam logic [30:0]   SLOP = 31'(((1 << FRAC_BITS) + 50) / 100);

	// floor(x / 5) = (x * RECIP5) >> 34 for any 32-bit x
	localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

	localparam logic [16:0] REST_RESET = 17'd52429;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_POS  = 2'd1,
		KIND_IMP  = 2'd2
	} kind_t;

	// body pair as it travels down the pipe
	typedef struct packed {
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] avx;
		logic [31:0] avy;
		logic [31:0] bx;
		logic [31:0] by;
		logic [31:0] bvx;
		logic [31:0] bvy;
		logic        xneg;
		logic        yneg;
		logic [30:0] udx;
		logic [30:0] udy;
		logic [30:0] ma;
		logic [30:0] mb;
		logic [30:0] radii;
		logic [30:0] dlen;
		logic        skip;
	} pay_t;

	// magnitude with sign applied
	function automatic logic signed [47:0] smag(input logic [46:0] mag, input logic neg);
		logic signed [47:0] m;
		m = $signed({1'b0, mag});
		return neg ? -m : m;
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic signed [47:0] v);
		logic signed [47:0] smax;
		logic signed [47:0] smin;
		smax = 48'sd2147483647;
		smin = -48'sd2147483648;
		if (v > smax) begin
			return 32'h7FFF_FFFF;
		end else if (v < smin) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// sign extend a 32-bit field
	function automatic logic signed [47:0] sx48(input logic [31:0] v);
		return 48'($signed(v));
	endfunction

endpackage

### rtl/core/cpci_sqrt.sv
// ----------------------------------------------------------------------------
// cpci_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module cpci_sqrt #(
	parameter int NB = 32
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*NB-1:0] rad,
	output logic [NB-1:0]   root
);

	logic [2*NB-1:0] rem_s [NB];
	logic [2*NB-1:0] res_s [NB];

	for (genvar i = 0; i < NB; i++) begin : g_st
		localparam logic [2*NB-1:0] BIT = (2*NB)'(1) << (2 * (NB - 1 - i));
		logic [2*NB-1:0] rem_in;
		logic [2*NB-1:0] res_in;
		logic [2*NB-1:0] trial;

		if (i == 0) begin : g_first
			assign rem_in = rad;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign res_in = res_s[i-1];
		end

		assign trial = res_in + BIT;

		// one restoring step
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[i] <= rem_in - trial;
					res_s[i] <= (res_in >> 1) + BIT;
				end else begin
					rem_s[i] <= rem_in;
					res_s[i] <= res_in >> 1;
				end
			end
		end
	end

	assign root = res_s[NB-1][NB-1:0];

endmodule

### rtl/core/cpci_div.sv
// ----------------------------------------------------------------------------
// cpci_div
// Pipelined restoring divider: floor(num * 2^UNIT_BITS / den) for num <= den,
// one quotient bit per register stage.
// ----------------------------------------------------------------------------
module cpci_div import cpci_pkg::*; #(
	parameter int W = 31
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	output logic [NQ-1:0] quo
);

	logic [W-1:0]  rem_s [NQ];
	logic [W-1:0]  den_s [NQ];
	logic [NQ-1:0] quo_s [NQ];

	for (genvar k = 0; k < NQ; k++) begin : g_st
		logic [W:0]    part;
		logic [W-1:0]  dv;
		logic [NQ-1:0] qin;
		logic          qb;

		if (k == 0) begin : g_first
			assign part = {1'b0, num};
			assign dv   = den;
			assign qin  = '0;
		end else begin : g_next
			assign part = {rem_s[k-1], 1'b0};
			assign dv   = den_s[k-1];
			assign qin  = quo_s[k-1];
		end

		assign qb = part >= {1'b0, dv};

		// compare, subtract, shift in one quotient bit
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= qb ? W'(part - {1'b0, dv}) : W'(part);
				den_s[k] <= dv;
				quo_s[k] <= {qin[NQ-2:0], qb};
			end
		end
	end

	assign quo = quo_s[NQ-1];

endmodule

### rtl/core/circle_pair_collision_impulse.sv
// ----------------------------------------------------------------------------
// circle_pair_collision_impulse
// Resolves one circle pair per beat: overlap push-out shared by inverse mass,
// then an impulse scaled by (1 + restitution) when the bodies approach.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid / in_stall       a_*, b_* bodies
//   output   out        out_valid / out_stall     new_a_*, new_b_*, contact_kind
//   config   in         restitution_we            restitution_wdata (Q1.16)
//
// A new beat is taken every cycle unless out_stall holds the pipe; the depth is set
// by the bit-per-stage square root (32 stages) and the normal dividers (25).
// Reset clears all valid bits and loads restitution with 0.8.
// out_stall with out_valid freezes the whole pipe and raises in_stall in the
// same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module circle_pair_collision_impulse import cpci_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        restitution_we,
	input  logic [16:0] restitution_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_vx,
	input  logic signed [31:0] a_vy,
	input  logic [30:0] a_width,
	input  logic [30:0] a_mass,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_vx,
	input  logic signed [31:0] b_vy,
	input  logic [30:0] b_width,
	input  logic [30:0] b_mass,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] new_a_x,
	output logic signed [31:0] new_a_y,
	output logic signed [31:0] new_a_vx,
	output logic signed [31:0] new_a_vy,
	output logic signed [31:0] new_b_x,
	output logic signed [31:0] new_b_y,
	output logic signed [31:0] new_b_vx,
	output logic signed [31:0] new_b_vy,
	output logic [1:0]  contact_kind
);

	logic        adv;
	logic [16:0] restitution_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= REST_RESET;
		end else if (restitution_we) begin
			restitution_q <= restitution_wdata;
		end
	end

	// whole pipe moves unless the output beat is held
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// ---------------- stage 1: deltas and radii ----------------
	logic [32:0] dx_c, dy_c, udx_c, udy_c;
	logic [31:0] wsum_c;
	pay_t        p_s1;
	logic [32:0] udx_s1, udy_s1;
	logic        v_s1;

	assign dx_c   = {b_x[31], b_x} - {a_x[31], a_x};
	assign dy_c   = {b_y[31], b_y} - {a_y[31], a_y};
	assign udx_c  = dx_c[32] ? 33'd0 - dx_c : dx_c;
	assign udy_c  = dy_c[32] ? 33'd0 - dy_c : dy_c;
	assign wsum_c = {1'b0, a_width} + {1'b0, b_width};

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1.ax    <= a_x;
			p_s1.ay    <= a_y;
			p_s1.avx   <= a_vx;
			p_s1.avy   <= a_vy;
			p_s1.bx    <= b_x;
			p_s1.by    <= b_y;
			p_s1.bvx   <= b_vx;
			p_s1.bvy   <= b_vy;
			p_s1.xneg  <= dx_c[32];
			p_s1.yneg  <= dy_c[32];
			p_s1.udx   <= '0;
			p_s1.udy   <= '0;
			p_s1.ma    <= a_mass;
			p_s1.mb    <= b_mass;
			p_s1.radii <= wsum_c[31:1];
			p_s1.dlen  <= '0;
			p_s1.skip  <= 1'b0;
			udx_s1     <= udx_c;
			udy_s1     <= udy_c;
		end
	end

	// ---------------- stage 2: coincident fixup, squares ----------------
	logic        coin_c, far_c;
	logic [30:0] ux_c, uy_c;
	pay_t        p_s2;
	logic [61:0] sqx_s2, sqy_s2;
	logic        v_s2;

	assign coin_c = (udx_s1 == '0) && (udy_s1 == '0);
	assign far_c  = (udx_s1 >= {2'b00, p_s1.radii}) || (udy_s1 >= {2'b00, p_s1.radii});
	assign ux_c   = coin_c ? SLOP : udx_s1[30:0];
	assign uy_c   = coin_c ? '0 : udy_s1[30:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2      <= p_s1;
			p_s2.udx  <= ux_c;
			p_s2.udy  <= uy_c;
			p_s2.skip <= ((p_s1.ma == '0) && (p_s1.mb == '0)) || (!coin_c && far_c);
			sqx_s2    <= {31'd0, ux_c} * {31'd0, ux_c};
			sqy_s2    <= {31'd0, uy_c} * {31'd0, uy_c};
		end
	end

	// ---------------- stage 3: squared distance ----------------
	pay_t        p_s3;
	logic [63:0] sum_s3;
	logic        v_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3   <= p_s2;
			sum_s3 <= 64'(sqx_s2) + 64'(sqy_s2);
		end
	end

	// ---------------- square root stages ----------------
	logic [SQ_BITS-1:0] root_w;
	pay_t               pay_sq_s [SQ_BITS];
	logic               v_sq_s   [SQ_BITS];

	cpci_sqrt #(.NB(SQ_BITS)) u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (sum_s3),
		.root (root_w)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_sq_s[0] <= p_s3;
			for (int i = 1; i < SQ_BITS; i++) begin
				pay_sq_s[i] <= pay_sq_s[i-1];
			end
		end
	end

	// ---------------- divider stages: normal and mass share ----------------
	pay_t        pq_c;
	logic        skip_dv_c;
	logic [31:0] msum_c;
	logic [NQ-1:0] nx_w, ny_w, wa_w;
	pay_t        pay_dv_s [NQ];
	logic        v_dv_s   [NQ];

	assign skip_dv_c = pay_sq_s[SQ_BITS-1].skip
		|| (root_w >= {1'b0, pay_sq_s[SQ_BITS-1].radii});
	assign msum_c = {1'b0, pay_sq_s[SQ_BITS-1].ma} + {1'b0, pay_sq_s[SQ_BITS-1].mb};

	always_comb begin
		pq_c      = pay_sq_s[SQ_BITS-1];
		pq_c.dlen = root_w[30:0];
		pq_c.skip = skip_dv_c;
	end

	cpci_div #(.W(31)) u_div_nx (
		.clk (clk),
		.en  (adv),
		.num (pay_sq_s[SQ_BITS-1].udx),
		.den (root_w[30:0]),
		.quo (nx_w)
	);

	cpci_div #(.W(31)) u_div_ny (
		.clk (clk),
		.en  (adv),
		.num (pay_sq_s[SQ_BITS-1].udy),
		.den (root_w[30:0]),
		.quo (ny_w)
	);

	cpci_div #(.W(32)) u_div_wa (
		.clk (clk),
		.en  (adv),
		.num ({1'b0, pay_sq_s[SQ_BITS-1].mb}),
		.den (msum_c),
		.quo (wa_w)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_dv_s[0] <= pq_c;
			for (int i = 1; i < NQ; i++) begin
				pay_dv_s[i] <= pay_dv_s[i-1];
			end
		end
	end

	// ---------------- stage 4: shares, penetration, relative velocity ----------------
	pay_t        pd_c;
	logic [NQ-1:0] wa_c;
	logic [30:0] pen_c, pm_c;
	logic [32:0] rvx_c, rvy_c;
	pay_t        p_s4;
	logic [NQ-1:0] nx_s4, ny_s4, wa_s4;
	logic [30:0] pm_s4;
	logic [32:0] rvxm_s4, rvym_s4;
	logic        svx_s4, svy_s4;
	logic        v_s4;

	assign pd_c  = pay_dv_s[NQ-1];
	assign wa_c  = (pd_c.ma == '0) ? '0 : (pd_c.mb == '0) ? UNIT : wa_w;
	assign pen_c = pd_c.radii - pd_c.dlen;
	assign pm_c  = (pen_c > SLOP) ? pen_c - SLOP : '0;
	assign rvx_c = {pd_c.bvx[31], pd_c.bvx} - {pd_c.avx[31], pd_c.avx};
	assign rvy_c = {pd_c.bvy[31], pd_c.bvy} - {pd_c.avy[31], pd_c.avy};

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4    <= pd_c;
			nx_s4   <= nx_w;
			ny_s4   <= ny_w;
			wa_s4   <= wa_c;
			pm_s4   <= pm_c;
			rvxm_s4 <= rvx_c[32] ? 33'd0 - rvx_c : rvx_c;
			rvym_s4 <= rvy_c[32] ? 33'd0 - rvy_c : rvy_c;
			svx_s4  <= rvx_c[32] ^ pd_c.xneg;
			svy_s4  <= rvy_c[32] ^ pd_c.yneg;
		end
	end

	// ---------------- stage 5: divide by five, normal velocity terms ----------------
	pay_t        p_s5;
	logic [NQ-1:0] nx_s5, ny_s5, wa_s5, wb_s5;
	logic [30:0] pm_s5;
	logic [63:0] prod5_s5;
	logic [57:0] pvx_s5, pvy_s5;
	logic        svx_s5, svy_s5;
	logic        v_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s5     <= p_s4;
			nx_s5    <= nx_s4;
			ny_s5    <= ny_s4;
			wa_s5    <= wa_s4;
			wb_s5    <= UNIT - wa_s4;
			pm_s5    <= pm_s4;
			prod5_s5 <= 64'({1'b0, pm_s4} + 32'd4) * 64'(RECIP5);
			pvx_s5   <= 58'(rvxm_s4) * 58'(nx_s4);
			pvy_s5   <= 58'(rvym_s4) * 58'(ny_s4);
			svx_s5   <= svx_s4;
			svy_s5   <= svy_s4;
		end
	end

	// ---------------- stage 6: correction depth, normal velocity ----------------
	pay_t        p_s6;
	logic [NQ-1:0] nx_s6, ny_s6, wa_s6, wb_s6;
	logic [30:0] corr_s6;
	logic signed [47:0] vn_s6;
	logic        v_s6;

	// 4p/5 = p - ceil(p/5)
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s6    <= p_s5;
			nx_s6   <= nx_s5;
			ny_s6   <= ny_s5;
			wa_s6   <= wa_s5;
			wb_s6   <= wb_s5;
			corr_s6 <= pm_s5 - 31'(prod5_s5[63:34]);
			vn_s6   <= smag(47'(pvx_s5[57:24]), svx_s5) + smag(47'(pvy_s5[57:24]), svy_s5);
		end
	end

	// ---------------- stage 7: push along normal, impulse magnitude ----------------
	logic [34:0] vnm_c;
	pay_t        p_s7;
	logic [NQ-1:0] nx_s7, ny_s7, wa_s7, wb_s7;
	logic [55:0] cnx_s7, cny_s7;
	logic [52:0] jp_s7;
	kind_t       kind_s7;
	logic        v_s7;

	assign vnm_c = vn_s6[47] ? 35'(-vn_s6) : 35'(vn_s6);

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s7    <= p_s6;
			nx_s7   <= nx_s6;
			ny_s7   <= ny_s6;
			wa_s7   <= wa_s6;
			wb_s7   <= wb_s6;
			cnx_s7  <= 56'(corr_s6) * 56'(nx_s6);
			cny_s7  <= 56'(corr_s6) * 56'(ny_s6);
			jp_s7   <= 53'(vnm_c) * 53'(18'd65536 + 18'(restitution_q));
			kind_s7 <= (vn_s6 > 48'sd0) ? KIND_POS : KIND_IMP;
		end
	end

	// ---------------- stage 8: share push and impulse by mass ----------------
	pay_t        p_s8;
	logic [NQ-1:0] nx_s8, ny_s8;
	logic [56:0] pax_s8, pay_s8, pbx_s8, pby_s8;
	logic [61:0] jap_s8, jbp_s8;
	kind_t       kind_s8;
	logic        v_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s8    <= p_s7;
			nx_s8   <= nx_s7;
			ny_s8   <= ny_s7;
			kind_s8 <= kind_s7;
			pax_s8  <= 57'(cnx_s7[55:24]) * 57'(wa_s7);
			pay_s8  <= 57'(cny_s7[55:24]) * 57'(wa_s7);
			pbx_s8  <= 57'(cnx_s7[55:24]) * 57'(wb_s7);
			pby_s8  <= 57'(cny_s7[55:24]) * 57'(wb_s7);
			jap_s8  <= 62'(jp_s7[52:16]) * 62'(wa_s7);
			jbp_s8  <= 62'(jp_s7[52:16]) * 62'(wb_s7);
		end
	end

	// ---------------- stage 9: new positions, impulse per axis ----------------
	pay_t        p_s9;
	logic [31:0] nax_s9, nay_s9, nbx_s9, nby_s9;
	logic [62:0] vax_s9, vay_s9, vbx_s9, vby_s9;
	kind_t       kind_s9;
	logic        v_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s9    <= p_s8;
			kind_s9 <= kind_s8;
			nax_s9  <= sat32(sx48(p_s8.ax) - smag(47'(pax_s8[56:24]), p_s8.xneg));
			nay_s9  <= sat32(sx48(p_s8.ay) - smag(47'(pay_s8[56:24]), p_s8.yneg));
			nbx_s9  <= sat32(sx48(p_s8.bx) + smag(47'(pbx_s8[56:24]), p_s8.xneg));
			nby_s9  <= sat32(sx48(p_s8.by) + smag(47'(pby_s8[56:24]), p_s8.yneg));
			vax_s9  <= 63'(jap_s8[61:24]) * 63'(nx_s8);
			vay_s9  <= 63'(jap_s8[61:24]) * 63'(ny_s8);
			vbx_s9  <= 63'(jbp_s8[61:24]) * 63'(nx_s8);
			vby_s9  <= 63'(jbp_s8[61:24]) * 63'(ny_s8);
		end
	end

	// ---------------- stage 10: velocities and result select ----------------
	logic        imp_c;
	logic [31:0] oax_s10, oay_s10, oavx_s10, oavy_s10;
	logic [31:0] obx_s10, oby_s10, obvx_s10, obvy_s10;
	kind_t       kind_s10;
	logic        v_s10;

	assign imp_c = !p_s9.skip && (kind_s9 == KIND_IMP);

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s10 <= p_s9.skip ? KIND_NONE : kind_s9;
			oax_s10  <= p_s9.skip ? p_s9.ax : nax_s9;
			oay_s10  <= p_s9.skip ? p_s9.ay : nay_s9;
			obx_s10  <= p_s9.skip ? p_s9.bx : nbx_s9;
			oby_s10  <= p_s9.skip ? p_s9.by : nby_s9;
			oavx_s10 <= imp_c
				? sat32(sx48(p_s9.avx) - smag(47'(vax_s9[62:24]), p_s9.xneg)) : p_s9.avx;
			oavy_s10 <= imp_c
				? sat32(sx48(p_s9.avy) - smag(47'(vay_s9[62:24]), p_s9.yneg)) : p_s9.avy;
			obvx_s10 <= imp_c
				? sat32(sx48(p_s9.bvx) + smag(47'(vbx_s9[62:24]), p_s9.xneg)) : p_s9.bvx;
			obvy_s10 <= imp_c
				? sat32(sx48(p_s9.bvy) + smag(47'(vby_s9[62:24]), p_s9.yneg)) : p_s9.bvy;
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int i = 0; i < SQ_BITS; i++) begin
				v_sq_s[i] <= 1'b0;
			end
			for (int i = 0; i < NQ; i++) begin
				v_dv_s[i] <= 1'b0;
			end
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_sq_s[0] <= v_s3;
			for (int i = 1; i < SQ_BITS; i++) begin
				v_sq_s[i] <= v_sq_s[i-1];
			end
			v_dv_s[0] <= v_sq_s[SQ_BITS-1];
			for (int i = 1; i < NQ; i++) begin
				v_dv_s[i] <= v_dv_s[i-1];
			end
			v_s4  <= v_dv_s[NQ-1];
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// ---------------- outputs ----------------
	assign out_valid    = v_s10;
	assign new_a_x      = oax_s10;
	assign new_a_y      = oay_s10;
	assign new_a_vx     = oavx_s10;
	assign new_a_vy     = oavy_s10;
	assign new_b_x      = obx_s10;
	assign new_b_y      = oby_s10;
	assign new_b_vx     = obvx_s10;
	assign new_b_vy     = obvy_s10;
	assign contact_kind = kind_s10;

	// ---------------- assertions ----------------
	// root lines up with its pair: a live contact never has root below |dx|
	a_root_align: assert property (@(posedge clk) disable iff (!arst_n)
		v_sq_s[SQ_BITS-1] && !skip_dv_c |-> root_w[30:0] >= pay_sq_s[SQ_BITS-1].udx)
		else $error("square root out of step with its pair");

	// normal components of a live contact are at most one
	a_normal_unit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !p_s4.skip |-> nx_s4 <= UNIT && ny_s4 <= UNIT)
		else $error("normal component above unit");

	// no contact means the pair leaves untouched
	a_none_passes: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s9 && p_s9.skip |=> out_valid && contact_kind == KIND_NONE
			&& new_a_vx == $past(p_s9.avx) && new_b_x == $past(p_s9.bx))
		else $error("separated pair was modified");

endmodule

### verif/circle_pair_collision_impulse_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_pair_collision_impulse_tb
// Streams circle pairs through the collision pipe and checks every updated
// body pair. Short table of corner cases first, then random pairs, most of
// them overlapping. Restitution changes between phases while the pipe is
// drained. Both handshakes get random gaps.
// ----------------------------------------------------------------------------
module circle_pair_collision_impulse_tb import cpci_pkg::*;;

	localparam int  LIMIT      = 400000;
	localparam int  DRAIN_WAIT = 80;
	localparam int  PHASE_LEN  = 80;
	localparam int  SLOP_Q     = ((1 << FRAC_BITS) + 50) / 100;

	typedef struct packed {
		logic [31:0] a_x, a_y, a_vx, a_vy;
		logic [30:0] a_width, a_mass;
		logic [31:0] b_x, b_y, b_vx, b_vy;
		logic [30:0] b_width, b_mass;
	} pair_t;

	typedef struct packed {
		logic [31:0] a_x, a_y, a_vx, a_vy, b_x, b_y, b_vx, b_vy;
		kind_t       kind;
	} bodies_t;

	typedef struct {
		pair_t   pair;
		bit      typed;
		bodies_t want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        restitution_we;
	logic [16:0] restitution_wdata;
	logic        in_valid;
	logic        in_stall;
	logic        out_valid;
	logic        out_stall;
	pair_t       pair_in;
	bodies_t     got;

	bodies_t     expected_bodies[$];
	logic [16:0] rest_copy;
	int          errors;
	int          pairs_sent;
	int          results_seen;
	int          cycles;
	bit          calm;
	int          stall_left;
	int          kind_count[3];

	circle_pair_collision_impulse u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.restitution_we    (restitution_we),
		.restitution_wdata (restitution_wdata),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.a_x               (pair_in.a_x),
		.a_y               (pair_in.a_y),
		.a_vx              (pair_in.a_vx),
		.a_vy              (pair_in.a_vy),
		.a_width           (pair_in.a_width),
		.a_mass            (pair_in.a_mass),
		.b_x               (pair_in.b_x),
		.b_y               (pair_in.b_y),
		.b_vx              (pair_in.b_vx),
		.b_vy              (pair_in.b_vy),
		.b_width           (pair_in.b_width),
		.b_mass            (pair_in.b_mass),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.new_a_x           (got.a_x),
		.new_a_y           (got.a_y),
		.new_a_vx          (got.a_vx),
		.new_a_vy          (got.a_vy),
		.new_b_x           (got.b_x),
		.new_b_y           (got.b_y),
		.new_b_vx          (got.b_vx),
		.new_b_vy          (got.b_vy),
		.contact_kind      (got.kind)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- predictor ----------------

	function automatic logic [63:0] mag64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint signed_of(logic [63:0] m, bit neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// Q0.24 scaling
	function automatic logic [63:0] unit_mul(logic [63:0] p, logic [63:0] q);
		return (p * q) >> UNIT_BITS;
	endfunction

	// floor square root, two bits per step
	function automatic logic [63:0] root_floor(logic [63:0] n);
		logic [63:0] acc;
		logic [63:0] b;
		acc = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= acc + b) begin
				n -= acc + b;
				acc = (acc >> 1) + b;
			end else begin
				acc >>= 1;
			end
			b >>= 2;
		end
		return acc;
	endfunction

	function automatic bodies_t unchanged(pair_t p);
		bodies_t r;
		r = '{p.a_x, p.a_y, p.a_vx, p.a_vy, p.b_x, p.b_y, p.b_vx, p.b_vy, KIND_NONE};
		return r;
	endfunction

	function automatic bodies_t resolve_pair(pair_t p, logic [16:0] rest);
		bodies_t     r;
		longint      ax, ay, avx, avy, bx, by, bvx, bvy, dx, dy, rvx, rvy, vn;
		logic [63:0] udx, udy, radii, dlen, wa, wb, nx, ny, pen, corr, j, ja, jb;
		logic [63:0] ma, mb;
		bit          xn, yn;
		r = unchanged(p);
		ax = $signed(p.a_x); ay = $signed(p.a_y);
		avx = $signed(p.a_vx); avy = $signed(p.a_vy);
		bx = $signed(p.b_x); by = $signed(p.b_y);
		bvx = $signed(p.b_vx); bvy = $signed(p.b_vy);
		ma = p.a_mass; mb = p.b_mass;
		dx = bx - ax; dy = by - ay;
		udx = mag64(dx); udy = mag64(dy);
		xn = dx < 0; yn = dy < 0;
		radii = (64'(p.a_width) + 64'(p.b_width)) >> 1;
		// immovable pair
		if (ma == 0 && mb == 0) return r;
		// coincident centers get a small x offset
		if (udx == 0 && udy == 0) begin
			udx = SLOP_Q;
			dlen = SLOP_Q;
		end else begin
			if (udx >= radii || udy >= radii) return r;
			dlen = root_floor(udx * udx + udy * udy);
		end
		if (dlen >= radii) return r;
		// mass shares
		if (ma == 0) wa = 0;
		else if (mb == 0) wa = 64'd1 << UNIT_BITS;
		else wa = (mb << UNIT_BITS) / (ma + mb);
		wb = (64'd1 << UNIT_BITS) - wa;
		nx = (udx << UNIT_BITS) / dlen;
		ny = (udy << UNIT_BITS) / dlen;
		// push apart
		pen = radii - dlen;
		corr = pen > SLOP_Q ? (pen - SLOP_Q) * 4 / 5 : 0;
		r.a_x = clamp32(ax - signed_of(unit_mul(unit_mul(corr, nx), wa), xn));
		r.a_y = clamp32(ay - signed_of(unit_mul(unit_mul(corr, ny), wa), yn));
		r.b_x = clamp32(bx + signed_of(unit_mul(unit_mul(corr, nx), wb), xn));
		r.b_y = clamp32(by + signed_of(unit_mul(unit_mul(corr, ny), wb), yn));
		// approach speed along the normal
		rvx = bvx - avx; rvy = bvy - avy;
		vn = signed_of(unit_mul(mag64(rvx), nx), (rvx < 0) != xn)
		   + signed_of(unit_mul(mag64(rvy), ny), (rvy < 0) != yn);
		if (vn > 0) begin
			r.kind = KIND_POS;
			return r;
		end
		j = (mag64(vn) * (64'd65536 + 64'(rest))) >> 16;
		ja = unit_mul(j, wa);
		jb = unit_mul(j, wb);
		r.a_vx = clamp32(avx - signed_of(unit_mul(ja, nx), xn));
		r.a_vy = clamp32(avy - signed_of(unit_mul(ja, ny), yn));
		r.b_vx = clamp32(bvx + signed_of(unit_mul(jb, nx), xn));
		r.b_vy = clamp32(bvy + signed_of(unit_mul(jb, ny), yn));
		r.kind = KIND_IMP;
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic pair_t make_pair(
		logic [31:0] ax, logic [31:0] ay, logic [31:0] avx, logic [31:0] avy,
		logic [30:0] aw, logic [30:0] am,
		logic [31:0] bx, logic [31:0] by, logic [31:0] bvx, logic [31:0] bvy,
		logic [30:0] bw, logic [30:0] bm);
		pair_t p;
		p = '{ax, ay, avx, avy, aw, am, bx, by, bvx, bvy, bw, bm};
		return p;
	endfunction

	// mostly short gaps, a few long, none in calm phases
	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [30:0] pick_mass();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 31'd0;
		if (r == 1) return 31'($urandom);
		return 31'($urandom_range(1, 1 << 20));
	endfunction

	function automatic logic [31:0] pick_speed();
		if ($urandom_range(0, 2) == 0) return $urandom;
		return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
	endfunction

	function automatic logic [31:0] offset_in(int span);
		logic [31:0] d;
		d = $urandom_range(0, span);
		return $urandom_range(0, 1) ? -d : d;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int    mode;
		int    span;
		mode = $urandom_range(0, 9);
		// raw noise, mostly far apart
		if (mode == 0) begin
			p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			return p;
		end
		span = 1 << $urandom_range(4, 24);
		p.a_x = $urandom;
		p.a_y = $urandom;
		// near the edges of the range so pushes saturate
		if (mode == 1) begin
			p.a_x = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, span)
			                             : 32'h8000_0000 + $urandom_range(0, span);
			p.a_y = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		end
		p.a_width = 31'($urandom_range(span, 3 * span));
		p.b_width = 31'($urandom_range(span / 2, 3 * span));
		if ($urandom_range(0, 15) == 0) p.a_width = 31'($urandom);
		if ($urandom_range(0, 15) == 0) p.b_width = 31'($urandom);
		p.b_x = p.a_x + offset_in(span);
		p.b_y = p.a_y + offset_in(span);
		if ($urandom_range(0, 19) == 0) begin
			p.b_x = p.a_x;
			p.b_y = p.a_y;
		end
		p.a_mass = pick_mass();
		p.b_mass = pick_mass();
		p.a_vx = pick_speed();
		p.a_vy = pick_speed();
		p.b_vx = pick_speed();
		p.b_vy = pick_speed();
		return p;
	endfunction

	// one beat on the input side, entered and left at a falling edge
	task automatic send_pair(pair_t p, bit typed, bodies_t want);
		int g;
		pair_in = p;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_bodies.push_back(typed ? want : resolve_pair(p, rest_copy));
		pairs_sent++;
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (expected_bodies.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic set_restitution(logic [16:0] v);
		wait_drained();
		restitution_we = 1'b1;
		restitution_wdata = v;
		@(negedge clk);
		restitution_we = 1'b0;
		rest_copy = v;
	endtask

	// ---------------- output side ----------------

	// receiver stall pattern
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left <= $urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
				                                          : $urandom_range(0, 2);
			end
		end
	end

	task automatic check_word(string name, logic [31:0] want, logic [31:0] have);
		if (want !== have) begin
			$display("%0t %s mismatch: expected %h, got %h", $time, name, want, have);
			errors++;
		end
	endtask

	// compare each accepted beat with the oldest expectation
	always @(posedge clk) begin
		bodies_t w;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_bodies.size() == 0) begin
				$display("%0t unexpected result beat: kind %0d", $time, got.kind);
				errors++;
			end else begin
				w = expected_bodies.pop_front();
				check_word("new_a_x", w.a_x, got.a_x);
				check_word("new_a_y", w.a_y, got.a_y);
				check_word("new_a_vx", w.a_vx, got.a_vx);
				check_word("new_a_vy", w.a_vy, got.a_vy);
				check_word("new_b_x", w.b_x, got.b_x);
				check_word("new_b_y", w.b_y, got.b_y);
				check_word("new_b_vx", w.b_vx, got.b_vx);
				check_word("new_b_vy", w.b_vy, got.b_vy);
				check_word("contact_kind", 32'(w.kind), 32'(got.kind));
				if (w.kind <= KIND_IMP) kind_count[w.kind]++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time,
			         expected_bodies.size());
			$display("circle_pair_collision_impulse_tb: FAIL");
			$finish;
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		row_t        rows[$];
		row_t        row;
		bodies_t     w;
		pair_t       p;
		logic [16:0] settings[6];
		arst_n = 1'b0;
		restitution_we = 1'b0;
		restitution_wdata = '0;
		in_valid = 1'b0;
		pair_in = '0;
		out_stall = 1'b0;
		stall_left = 0;
		errors = 0;
		pairs_sent = 0;
		results_seen = 0;
		cycles = 0;
		calm = 1'b0;
		rest_copy = REST_RESET;

		// corner cases; typed expectations where obvious
		// coincident centers, equal masses, at rest: push of 25690 each way
		p = make_pair(0, 0, 0, 0, 31'h10000, 31'h10000, 0, 0, 0, 0, 31'h10000, 31'h10000);
		w = unchanged(p);
		w.a_x = -32'sd25690;
		w.b_x = 32'sd25690;
		w.kind = KIND_IMP;
		rows.push_back('{p, 1'b1, w});
		// both masses zero, overlapping
		p = make_pair(0, 0, 5, 6, 31'h20000, 0, 100, 100, -5, -6, 31'h20000, 0);
		rows.push_back('{p, 1'b1, unchanged(p)});
		// far apart along x
		p = make_pair(0, 0, 1, 0, 31'h10000, 9, 32'h40000, 0, -1, 0, 31'h10000, 9);
		rows.push_back('{p, 1'b1, unchanged(p)});
		// far apart along y only
		p = make_pair(0, 0, 0, 1, 31'h10000, 9, 0, 32'h10000, 0, -1, 31'h10000, 9);
		rows.push_back('{p, 1'b1, unchanged(p)});
		// each axis inside but the distance outside
		p = make_pair(0, 0, 0, 0, 31'h10000, 9, 50000, 50000, 0, 0, 31'h10000, 9);
		rows.push_back('{p, 1'b1, unchanged(p)});
		// zero widths, coincident
		p = make_pair(7, 7, 0, 0, 0, 9, 7, 7, 0, 0, 0, 9);
		rows.push_back('{p, 1'b1, unchanged(p)});
		// extreme separation, largest radii
		p = make_pair(32'h8000_0000, 0, 0, 0, 31'h7FFF_FFFF, 1,
		              32'h7FFF_FFFF, 0, 0, 0, 31'h7FFF_FFFF, 1);
		rows.push_back('{p, 1'b1, unchanged(p)});
		// touching at rest
		p = make_pair(0, 0, 0, 0, 31'h10000, 31'h10000, 32'h8000, 32'h4000, 0, 0,
		              31'h10000, 31'h20000);
		rows.push_back('{p, 1'b0, w});
		// head-on approach
		p = make_pair(0, 0, 32'h10000, 0, 31'h20000, 31'h10000, 32'h18000, 0,
		              -32'sh10000, 0, 31'h20000, 31'h10000);
		rows.push_back('{p, 1'b0, w});
		// separating
		p = make_pair(0, 0, -32'sh10000, 0, 31'h20000, 31'h10000, 32'h18000, 32'h1000,
		              32'h10000, 0, 31'h20000, 31'h10000);
		rows.push_back('{p, 1'b0, w});
		// one body immovable, then the other
		p = make_pair(100, 200, 32'h30000, -32'sh20000, 31'h40000, 0, 32'h20000, 32'h10000,
		              -32'sh10000, 32'h5000, 31'h40000, 31'h12345);
		rows.push_back('{p, 1'b0, w});
		p.a_mass = 31'h7FFF_FFFF;
		p.b_mass = 0;
		rows.push_back('{p, 1'b0, w});
		// saturation at the top corner, widest bodies, extreme speeds
		p = make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
		              31'h7FFF_FFFF, 31'h7FFF_FFFF,
		              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
		              31'h7FFF_FFFF, 31'h7FFF_FFFF);
		rows.push_back('{p, 1'b0, w});
		// saturation at the bottom corner
		p = make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
		              31'h7FFF_FFFF, 1,
		              32'h8000_1000, 32'h8000_0800, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
		              31'h7FFF_FFFF, 31'h7FFF_FFFF);
		rows.push_back('{p, 1'b0, w});
		// negative normal components
		p = make_pair(32'h50000, 32'h50000, -32'sh8000, 32'h9000, 31'h80000, 31'h3000,
		              32'h20000, 32'h30000, 32'h7000, -32'sh6000, 31'h60000, 31'h5000);
		rows.push_back('{p, 1'b0, w});

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part at the reset restitution
		foreach (rows[i]) begin
			row = rows[i];
			send_pair(row.pair, row.typed, row.want);
		end

		// random phases across restitution settings
		settings = '{17'd0, 17'd65536, 17'h1FFFF, REST_RESET, 17'd0, 17'd0};
		settings[4] = 17'($urandom_range(0, 65536));
		settings[5] = 17'($urandom);
		foreach (settings[k]) begin
			set_restitution(settings[k]);
			calm = (k == 2);
			@(negedge clk);
			repeat (PHASE_LEN) send_pair(random_pair(), 1'b0, w);
			calm = 1'b0;
		end

		wait_drained();
		$display("sent %0d pairs, %0d results: %0d untouched, %0d pushed, %0d with impulse",
		         pairs_sent, results_seen, kind_count[0], kind_count[1], kind_count[2]);
		$display("restitution covered 0, 1.0, the 17-bit maximum, reset and random values");
		if (errors == 0) begin
			$display("circle_pair_collision_impulse_tb: PASS");
		end else begin
			$display("circle_pair_collision_impulse_tb: FAIL");
		end
		$finish;
	end

endmodule
